// File: design/sbef_pkg.sv
package sbef_pkg;

   localparam int IDX_W       = 10;
   localparam int STEP_W      = 16;
   localparam int GRID_REG_W  = 11;
   localparam int FOLD_CMP_W  = GRID_REG_W + 1;
   localparam int FOLD_W      = 11;
   localparam int KABS_W      = FOLD_W + STEP_W;
   localparam int KSQ_W       = 2 * KABS_W;
   localparam int K2_W        = KSQ_W + 2;
   localparam int PORT_COEF_W = 32;
   localparam int SQ_W        = 64;
   localparam int ACC_W       = 63;
   localparam int K2_FRAC     = 24;
   localparam int LO_W        = 32;
   localparam int NUM_COEF    = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int RSP_DEPTH   = 2;

   localparam logic [ACC_W-1:0] ACC_MAX    = '1;
   localparam logic [K2_W-1:0]  BAND_LIMIT = K2_W'(4) << K2_FRAC;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_STEP_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_STEP_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_STEP_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_X      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_Y      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_Z      = 3'd5;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      step_type x;
      step_type y;
      step_type z;
   } wave_step_type;

   typedef struct packed {
      logic [KABS_W-1:0]                        kabs_x;
      logic [KABS_W-1:0]                        kabs_y;
      logic [KABS_W-1:0]                        kabs_z;
      logic [NUM_COEF-1:0][SQ_W-1:0]            coef_sq;
      logic [NUM_COEF-1:0][PORT_COEF_W-1:0]     coef;
      logic                                     plane;
      logic                                     last;
   } mode_type;

   typedef struct packed {
      logic [NUM_COEF-1:0][PORT_COEF_W-1:0] coef;
      logic [ACC_W-1:0]                     total_energy;
      logic [ACC_W-1:0]                     dissipation_sum;
      logic [ACC_W-1:0]                     band_energy;
      logic                                 totals_valid;
   } result_type;

   function automatic logic [FOLD_W-1:0] fold_abs(input logic [IDX_W-1:0] idx,
                                                  input logic [GRID_REG_W-1:0] n);
      logic [FOLD_CMP_W-1:0] i_ext;
      logic [FOLD_CMP_W-1:0] n_ext;
      logic [FOLD_CMP_W-1:0] r;
      i_ext = FOLD_CMP_W'(idx);
      n_ext = FOLD_CMP_W'(n);
      if (i_ext <= (n_ext >> 1)) begin
         r = i_ext;
      end else if (i_ext >= n_ext) begin
         r = i_ext - n_ext;
      end else begin
         r = n_ext - i_ext;
      end
      return r[FOLD_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
   endfunction

endpackage

// File: design/spectral_band_energy_filter.sv
// Spectral energy band filter. Each input beat on the req_ queue carries one
// Fourier mode: three grid indices, the complex u, v and w coefficients and a
// last-mode flag. An input beat is taken when req_push is high and req_full
// is low. Every mode yields exactly one result beat on the rsp_ queue: the
// coefficients (zeroed outside the band 0 < |k| <= 2) and, on the last mode,
// the saturated energy, dissipation and band-energy sums, which then clear.
// A result beat is taken when rsp_pop is high and rsp_empty is low.
// The csr_ channel writes the wave steps and grid sizes; csr_ready is always
// high, and writes are meant to happen only while no mode is in flight.
// A mode passes the front stages, the mode queue, the back stages and the
// result queue in turn, and one mode is taken every cycle while results are
// drained: two front stages (folding, wave and coefficient products) feed a
// 4-entry queue, and four back stages (squares, k2 and energy, split product,
// dissipation) end in the accumulators and a 2-entry result queue.
// When the receiver stalls, the result queue fills, the back stages freeze,
// then the middle queue fills and req_full rises until beats are popped.
// Reset empties both queues, clears the sums and restores the default steps
// and grid sizes; no clearing pass follows.
module spectral_band_energy_filter
   import sbef_pkg::*;
#(
   parameter int MAX_GRID   = 1024,
   parameter int COEF_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,

   input  logic                          req_push,
   output logic                          req_full,
   input  logic [IDX_W-1:0]              req_x_index,
   input  logic [IDX_W-1:0]              req_y_index,
   input  logic [IDX_W-1:0]              req_z_index,
   input  logic signed [PORT_COEF_W-1:0] req_u_re,
   input  logic signed [PORT_COEF_W-1:0] req_u_im,
   input  logic signed [PORT_COEF_W-1:0] req_v_re,
   input  logic signed [PORT_COEF_W-1:0] req_v_im,
   input  logic signed [PORT_COEF_W-1:0] req_w_re,
   input  logic signed [PORT_COEF_W-1:0] req_w_im,
   input  logic                          req_last_mode,

   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [PORT_COEF_W-1:0] rsp_out_u_re,
   output logic signed [PORT_COEF_W-1:0] rsp_out_u_im,
   output logic signed [PORT_COEF_W-1:0] rsp_out_v_re,
   output logic signed [PORT_COEF_W-1:0] rsp_out_v_im,
   output logic signed [PORT_COEF_W-1:0] rsp_out_w_re,
   output logic signed [PORT_COEF_W-1:0] rsp_out_w_im,
   output logic [ACC_W-1:0]              rsp_total_energy,
   output logic [ACC_W-1:0]              rsp_dissipation_sum,
   output logic [ACC_W-1:0]              rsp_band_energy,
   output logic                          rsp_totals_valid
);

   localparam int GridBits = $clog2(MAX_GRID + 1);
   localparam int GridW    = (GridBits < 7) ? 7 :
                             ((GridBits > GRID_REG_W) ? GRID_REG_W : GridBits);

   wave_step_type    wave_step_ff;
   logic [GridW-1:0] grid_x_ff, grid_y_ff, grid_z_ff;
   logic [GridW-1:0] grid_clamped_in;
   logic [GRID_REG_W-1:0] grid_wr;
   logic             csr_write;

   logic [NUM_COEF-1:0][PORT_COEF_W-1:0] coef_in;

   logic       q_push, q_full, q_pop, q_empty;
   mode_type   q_wr_data, q_rd_data;
   logic       out_push, out_full, out_pop;
   result_type out_wr_data, out_rd_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign grid_wr   = csr_wdata[GRID_REG_W-1:0];

   always_comb begin
      if (int'(grid_wr) > MAX_GRID) begin
         grid_clamped_in = GridW'(MAX_GRID);
      end else begin
         grid_clamped_in = GridW'(grid_wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_step_ff.x <= STEP_W'(25736);
         wave_step_ff.y <= STEP_W'(25736);
         wave_step_ff.z <= STEP_W'(25736);
         grid_x_ff      <= GridW'(64);
         grid_y_ff      <= GridW'(64);
         grid_z_ff      <= GridW'(64);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WAVE_STEP_X: begin
               wave_step_ff.x <= csr_wdata;
            end
            CSR_WAVE_STEP_Y: begin
               wave_step_ff.y <= csr_wdata;
            end
            CSR_WAVE_STEP_Z: begin
               wave_step_ff.z <= csr_wdata;
            end
            CSR_GRID_X: begin
               grid_x_ff <= grid_clamped_in;
            end
            CSR_GRID_Y: begin
               grid_y_ff <= grid_clamped_in;
            end
            CSR_GRID_Z: begin
               grid_z_ff <= grid_clamped_in;
            end
            default: begin
            end
         endcase
      end
   end

   assign coef_in = {req_w_im, req_w_re, req_v_im, req_v_re, req_u_im, req_u_re};

   sbef_front #(
      .GridW (GridW),
      .CoefW (COEF_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .wave_step (wave_step_ff),
      .grid_x    (grid_x_ff),
      .grid_y    (grid_y_ff),
      .grid_z    (grid_z_ff),
      .push      (req_push),
      .full      (req_full),
      .x_index   (req_x_index),
      .y_index   (req_y_index),
      .z_index   (req_z_index),
      .coef_in   (coef_in),
      .last_mode (req_last_mode),
      .q_push    (q_push),
      .q_data    (q_wr_data),
      .q_full    (q_full)
   );

   sbef_fifo #(
      .Width ($bits(mode_type)),
      .Depth (QUEUE_DEPTH)
   ) u_mode_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   sbef_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_rd_data),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_wr_data)
   );

   assign out_pop = rsp_pop && !rsp_empty;

   sbef_fifo #(
      .Width ($bits(result_type)),
      .Depth (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_data),
      .full      (out_full),
      .pop       (out_pop),
      .pop_data  (out_rd_data),
      .empty     (rsp_empty)
   );

   assign rsp_out_u_re        = out_rd_data.coef[0];
   assign rsp_out_u_im        = out_rd_data.coef[1];
   assign rsp_out_v_re        = out_rd_data.coef[2];
   assign rsp_out_v_im        = out_rd_data.coef[3];
   assign rsp_out_w_re        = out_rd_data.coef[4];
   assign rsp_out_w_im        = out_rd_data.coef[5];
   assign rsp_total_energy    = out_rd_data.total_energy;
   assign rsp_dissipation_sum = out_rd_data.dissipation_sum;
   assign rsp_band_energy     = out_rd_data.band_energy;
   assign rsp_totals_valid    = out_rd_data.totals_valid;

   a_mode_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("Mode queue written while full.");

   a_rsp_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full))
      else $error("Result queue written while full.");

   a_totals_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_totals_valid) |->
         (rsp_total_energy == '0 && rsp_dissipation_sum == '0 && rsp_band_energy == '0))
      else $error("Nonzero sums on a beat that is not the last mode.");

endmodule

// File: design/sbef_fifo.sv
module sbef_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/sbef_front.sv
module sbef_front
   import sbef_pkg::*;
#(
   parameter int GridW = 11,
   parameter int CoefW = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wave_step_type                        wave_step,
   input  logic [GridW-1:0]                     grid_x,
   input  logic [GridW-1:0]                     grid_y,
   input  logic [GridW-1:0]                     grid_z,
   input  logic                                 push,
   output logic                                 full,
   input  logic [IDX_W-1:0]                     x_index,
   input  logic [IDX_W-1:0]                     y_index,
   input  logic [IDX_W-1:0]                     z_index,
   input  logic [NUM_COEF-1:0][PORT_COEF_W-1:0] coef_in,
   input  logic                                 last_mode,
   output logic                                 q_push,
   output mode_type                             q_data,
   input  logic                                 q_full
);

   localparam int SqW = 2 * CoefW;

   logic enable;

   logic                                 f1_valid_ff;
   logic [2:0][FOLD_W-1:0]               f1_fold_ff, f1_fold_in;
   logic [NUM_COEF-1:0][CoefW-1:0]       f1_abs_ff, f1_abs_in;
   logic [NUM_COEF-1:0][PORT_COEF_W-1:0] f1_coef_ff, f1_coef_in;
   logic                                 f1_plane_ff, f1_plane_in;
   logic                                 f1_last_ff;

   logic     f2_valid_ff;
   mode_type f2_mode_ff, f2_mode_in;

   assign enable = !(f2_valid_ff && q_full);
   assign full   = !enable;
   assign q_push = f2_valid_ff && !q_full;
   assign q_data = f2_mode_ff;

   always_comb begin
      logic [CoefW-1:0] low;
      f1_fold_in[0] = fold_abs(x_index, GRID_REG_W'(grid_x));
      f1_fold_in[1] = fold_abs(y_index, GRID_REG_W'(grid_y));
      f1_fold_in[2] = fold_abs(z_index, GRID_REG_W'(grid_z));
      f1_plane_in   = (z_index == '0) ||
                      (GRID_REG_W'(z_index) == GRID_REG_W'(grid_z >> 1));
      for (int i = 0; i < NUM_COEF; i++) begin
         low           = coef_in[i][CoefW-1:0];
         f1_coef_in[i] = PORT_COEF_W'(signed'(low));
         f1_abs_in[i]  = low[CoefW-1] ? (~low + CoefW'(1)) : low;
      end
   end

   always_comb begin
      logic [SqW-1:0] sq;
      f2_mode_in.kabs_x = KABS_W'(f1_fold_ff[0]) * KABS_W'(wave_step.x);
      f2_mode_in.kabs_y = KABS_W'(f1_fold_ff[1]) * KABS_W'(wave_step.y);
      f2_mode_in.kabs_z = KABS_W'(f1_fold_ff[2]) * KABS_W'(wave_step.z);
      for (int i = 0; i < NUM_COEF; i++) begin
         sq                    = SqW'(f1_abs_ff[i]) * SqW'(f1_abs_ff[i]);
         f2_mode_in.coef_sq[i] = SQ_W'(sq);
      end
      f2_mode_in.coef  = f1_coef_ff;
      f2_mode_in.plane = f1_plane_ff;
      f2_mode_in.last  = f1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (enable) begin
         f1_valid_ff <= push;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         f1_fold_ff  <= f1_fold_in;
         f1_abs_ff   <= f1_abs_in;
         f1_coef_ff  <= f1_coef_in;
         f1_plane_ff <= f1_plane_in;
         f1_last_ff  <= last_mode;
         f2_mode_ff  <= f2_mode_in;
      end
   end

endmodule

// File: design/sbef_back.sv
module sbef_back
   import sbef_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   output logic       q_pop,
   input  mode_type   q_data,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_data
);

   localparam int SSUM_W = SQ_W + 3;
   localparam int KH_W   = K2_W - LO_W;
   localparam int EH_W   = ACC_W - LO_W;
   localparam int PROD_W = K2_W + ACC_W;
   localparam int SAT_LO = ACC_W + K2_FRAC;

   typedef struct packed {
      logic [NUM_COEF-1:0][PORT_COEF_W-1:0] coef;
      logic                                 last;
   } carry_type;

   logic adv;

   logic              b1_valid_ff;
   logic [2:0][KSQ_W-1:0] b1_ksq_ff, b1_ksq_in;
   logic [ACC_W-1:0]  b1_s_ff, b1_s_in;
   logic              b1_plane_ff;
   carry_type         b1_carry_ff;

   logic              b2_valid_ff;
   logic [K2_W-1:0]   b2_k2_ff, b2_k2_in;
   logic [ACC_W-1:0]  b2_e_ff, b2_e_in;
   logic              b2_band_ff, b2_band_in;
   carry_type         b2_carry_ff;

   logic                   b3_valid_ff;
   logic [2*LO_W-1:0]      b3_ll_ff, b3_ll_in;
   logic [LO_W+EH_W-1:0]   b3_lh_ff, b3_lh_in;
   logic [KH_W+LO_W-1:0]   b3_hl_ff, b3_hl_in;
   logic [KH_W+EH_W-1:0]   b3_hh_ff, b3_hh_in;
   logic [ACC_W-1:0]       b3_e_ff;
   logic                   b3_band_ff;
   carry_type              b3_carry_ff;

   logic              b4_valid_ff;
   logic [ACC_W-1:0]  b4_diss_ff, b4_diss_in;
   logic [ACC_W-1:0]  b4_e_ff;
   logic              b4_band_ff;
   carry_type         b4_carry_ff;

   logic [ACC_W-1:0] energy_acc_ff, energy_acc_in;
   logic [ACC_W-1:0] dissipation_acc_ff, dissipation_acc_in;
   logic [ACC_W-1:0] band_acc_ff, band_acc_in;

   assign adv      = !(b4_valid_ff && out_full);
   assign q_pop    = adv && !q_empty;
   assign out_push = b4_valid_ff && !out_full;

   always_comb begin
      logic [SSUM_W-1:0] sum_a, sum_b, sum_c, ssum;
      b1_ksq_in[0] = KSQ_W'(q_data.kabs_x) * KSQ_W'(q_data.kabs_x);
      b1_ksq_in[1] = KSQ_W'(q_data.kabs_y) * KSQ_W'(q_data.kabs_y);
      b1_ksq_in[2] = KSQ_W'(q_data.kabs_z) * KSQ_W'(q_data.kabs_z);
      sum_a = SSUM_W'(q_data.coef_sq[0]) + SSUM_W'(q_data.coef_sq[1]);
      sum_b = SSUM_W'(q_data.coef_sq[2]) + SSUM_W'(q_data.coef_sq[3]);
      sum_c = SSUM_W'(q_data.coef_sq[4]) + SSUM_W'(q_data.coef_sq[5]);
      ssum  = sum_a + sum_b + sum_c;
      b1_s_in = (ssum > SSUM_W'(ACC_MAX)) ? ACC_MAX : ssum[ACC_W-1:0];
   end

   always_comb begin
      b2_k2_in   = K2_W'(b1_ksq_ff[0]) + K2_W'(b1_ksq_ff[1]) + K2_W'(b1_ksq_ff[2]);
      b2_e_in    = b1_plane_ff ? (b1_s_ff >> 1) : b1_s_ff;
      b2_band_in = (b2_k2_in != '0) && (b2_k2_in <= BAND_LIMIT);
   end

   always_comb begin
      logic [LO_W-1:0] k_lo, e_lo;
      logic [KH_W-1:0] k_hi;
      logic [EH_W-1:0] e_hi;
      k_lo = b2_k2_ff[LO_W-1:0];
      k_hi = b2_k2_ff[K2_W-1:LO_W];
      e_lo = b2_e_ff[LO_W-1:0];
      e_hi = b2_e_ff[ACC_W-1:LO_W];
      b3_ll_in = (2*LO_W)'(k_lo) * (2*LO_W)'(e_lo);
      b3_lh_in = (LO_W+EH_W)'(k_lo) * (LO_W+EH_W)'(e_hi);
      b3_hl_in = (KH_W+LO_W)'(k_hi) * (KH_W+LO_W)'(e_lo);
      b3_hh_in = (KH_W+EH_W)'(k_hi) * (KH_W+EH_W)'(e_hi);
   end

   always_comb begin
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(b3_ll_ff) + (PROD_W'(b3_lh_ff) << LO_W) +
             (PROD_W'(b3_hl_ff) << LO_W) + (PROD_W'(b3_hh_ff) << (2 * LO_W));
      b4_diss_in = (|prod[PROD_W-1:SAT_LO]) ? ACC_MAX : prod[SAT_LO-1:K2_FRAC];
   end

   always_comb begin
      logic [ACC_W-1:0] energy_sum, diss_sum, band_sum;
      energy_sum = sat_add(energy_acc_ff, b4_e_ff);
      diss_sum   = sat_add(dissipation_acc_ff, b4_diss_ff);
      band_sum   = b4_band_ff ? sat_add(band_acc_ff, b4_e_ff) : band_acc_ff;

      out_data.coef            = b4_band_ff ? b4_carry_ff.coef : '0;
      out_data.total_energy    = b4_carry_ff.last ? energy_sum : '0;
      out_data.dissipation_sum = b4_carry_ff.last ? diss_sum : '0;
      out_data.band_energy     = b4_carry_ff.last ? band_sum : '0;
      out_data.totals_valid    = b4_carry_ff.last;

      energy_acc_in      = energy_acc_ff;
      dissipation_acc_in = dissipation_acc_ff;
      band_acc_in        = band_acc_ff;
      if (out_push) begin
         energy_acc_in      = b4_carry_ff.last ? '0 : energy_sum;
         dissipation_acc_in = b4_carry_ff.last ? '0 : diss_sum;
         band_acc_in        = b4_carry_ff.last ? '0 : band_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff        <= 1'b0;
         b2_valid_ff        <= 1'b0;
         b3_valid_ff        <= 1'b0;
         b4_valid_ff        <= 1'b0;
         energy_acc_ff      <= '0;
         dissipation_acc_ff <= '0;
         band_acc_ff        <= '0;
      end else begin
         if (adv) begin
            b1_valid_ff <= !q_empty;
            b2_valid_ff <= b1_valid_ff;
            b3_valid_ff <= b2_valid_ff;
            b4_valid_ff <= b3_valid_ff;
         end
         energy_acc_ff      <= energy_acc_in;
         dissipation_acc_ff <= dissipation_acc_in;
         band_acc_ff        <= band_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ksq_ff        <= b1_ksq_in;
         b1_s_ff          <= b1_s_in;
         b1_plane_ff      <= q_data.plane;
         b1_carry_ff.coef <= q_data.coef;
         b1_carry_ff.last <= q_data.last;

         b2_k2_ff    <= b2_k2_in;
         b2_e_ff     <= b2_e_in;
         b2_band_ff  <= b2_band_in;
         b2_carry_ff <= b1_carry_ff;

         b3_ll_ff    <= b3_ll_in;
         b3_lh_ff    <= b3_lh_in;
         b3_hl_ff    <= b3_hl_in;
         b3_hh_ff    <= b3_hh_in;
         b3_e_ff     <= b2_e_ff;
         b3_band_ff  <= b2_band_ff;
         b3_carry_ff <= b2_carry_ff;

         b4_diss_ff  <= b4_diss_in;
         b4_e_ff     <= b3_e_ff;
         b4_band_ff  <= b3_band_ff;
         b4_carry_ff <= b3_carry_ff;
      end
   end

endmodule
